// ===== hdl/dft_pkg.sv =====
`default_nettype none

package dft_pkg;

  localparam int DFT_CONTEXTS = 4;
  localparam int DFT_SLOTS    = 8;

  // opcodes of a request
  localparam logic [2:0] OP_FOCUS = 3'd0;
  localparam logic [2:0] OP_DECAY = 3'd1;
  localparam logic [2:0] OP_QUERY = 3'd2;
  localparam logic [2:0] OP_TOUCH = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_FOCUS_ENABLE    = 3'd0;
  localparam logic [2:0] REG_ATTENTION_BOOST = 3'd1;
  localparam logic [2:0] REG_DECAY_RATE      = 3'd2;
  localparam logic [2:0] REG_PRUNE_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_TABLE_LIMIT     = 3'd4;
  localparam logic [2:0] REG_SCORE_CEILING   = 3'd5;

  localparam logic [15:0] HALF_SCORE = 16'd2048;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [1:0]         context_index;
    logic [31:0]        item_id;
    logic signed [15:0] extra_boost;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] score_out;
    logic [31:0] last_tick_out;
    logic [3:0]  entry_count;
  } out_t;

  typedef enum logic [2:0] {
    KIND_READ,
    KIND_FOCUS,
    KIND_DECAY,
    KIND_TOUCH,
    KIND_CLEAR
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_APPLY,
    ST_PRUNE,
    ST_SORT,
    ST_COUNT,
    ST_STORE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic start;
    logic load;
    logic apply;
    logic prune;
    logic sort;
    logic count;
    logic store;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic  load_done;
    logic  sort_done;
    logic  store_done;
    logic  out_busy;
    kind_t kind;
  } stat_t;

endpackage

`default_nettype wire

// ===== hdl/decaying_focus_table.sv =====
// a query or clear loads the context's entries, then responds; a touch stores them back first;
// focus and decay load, apply, prune, sort, count the kept entries and store them, then respond
// throughput: one request at a time; the table load and store sweeps and the buffer sort set it
// the result register lets the next request in while a result waits to be taken
// reset (synchronous, rst_n low): all contexts empty, tick zero, registers at their defaults
`default_nettype none

module decaying_focus_table import dft_pkg::*; #(
  parameter int CONTEXTS = DFT_CONTEXTS,
  parameter int SLOTS    = DFT_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  dft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dft_datapath #(
    .CONTEXTS (CONTEXTS),
    .SLOTS    (SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.apply, cmd.prune, cmd.sort, cmd.count, cmd.store, cmd.respond}))
    else $error("more than one datapath phase active");

  a_respond_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |=> out_valid)
    else $error("result not presented after respond");

  a_respond_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |-> !out_valid || out_ready)
    else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire

// ===== hdl/dft_ctrl.sv =====
`default_nettype none

module dft_ctrl import dft_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (stat.load_done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        unique case (stat.kind)
          KIND_FOCUS, KIND_DECAY: state_nxt = ST_PRUNE;
          KIND_TOUCH:             state_nxt = ST_STORE;
          default:                state_nxt = ST_RESP;
        endcase
      end
      ST_PRUNE: begin
        cmd.prune = 1'b1;
        state_nxt = ST_SORT;
      end
      ST_SORT: begin
        cmd.sort = 1'b1;
        if (stat.sort_done) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (stat.store_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!stat.out_busy) begin
          cmd.respond = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/dft_datapath.sv =====
`default_nettype none

module dft_datapath import dft_pkg::*; #(
  parameter int CONTEXTS = DFT_CONTEXTS,
  parameter int SLOTS    = DFT_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_t         in_data,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  localparam int NB    = SLOTS + 1;
  localparam int IW    = $clog2(NB);
  localparam int CW    = $clog2(SLOTS + 2);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CXW   = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int DEPTH = CONTEXTS * (1 << SW);

  // configuration
  logic        en_r;
  logic [15:0] boost_r, rate_r, thr_r, ceil_r;
  logic [3:0]  lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b1;
      boost_r <= 16'd819;
      rate_r  <= 16'd3277;
      thr_r   <= 16'd410;
      lim_r   <= 4'd8;
      ceil_r  <= 16'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FOCUS_ENABLE:    en_r    <= cfg_data[0];
        REG_ATTENTION_BOOST: boost_r <= cfg_data;
        REG_DECAY_RATE:      rate_r  <= cfg_data;
        REG_PRUNE_THRESHOLD: thr_r   <= cfg_data;
        REG_TABLE_LIMIT:     lim_r   <= cfg_data[3:0];
        REG_SCORE_CEILING:   ceil_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // request and working buffer
  logic [CXW-1:0]     ctx_r;
  logic [31:0]        id_r;
  logic signed [15:0] extra_r;
  kind_t              kind_r;
  logic [31:0]        gtick_r;
  logic [CW-1:0]      n_r, cnt_r;
  logic [CW-1:0]      fill_r [CONTEXTS];
  logic [NB-1:0]      vld_r;
  logic [31:0]        bid_r [NB];
  logic [15:0]        bsc_r [NB];
  logic [31:0]        btk_r [NB];

  // table storage
  logic [31:0] mem_id [DEPTH];
  logic [15:0] mem_sc [DEPTH];
  logic [31:0] mem_tk [DEPTH];
  logic [31:0] rd_id_r, rd_tk_r;
  logic [15:0] rd_sc_r;

  logic in_range, read_en, write_en;
  logic [CXW+SW-1:0] addr;
  logic [CW-1:0]     cnt_m1;

  assign in_range = 32'(in_data.context_index) < 32'(CONTEXTS);
  assign addr     = {ctx_r, cnt_r[SW-1:0]};
  assign read_en  = cmd.load && (cnt_r < n_r);
  assign write_en = cmd.store && (cnt_r < n_r);
  assign cnt_m1   = cnt_r - CW'(1);

  always_ff @(posedge clk) begin
    if (read_en) begin
      rd_id_r <= mem_id[addr];
      rd_sc_r <= mem_sc[addr];
      rd_tk_r <= mem_tk[addr];
    end
    if (write_en) begin
      mem_id[addr] <= bid_r[cnt_r[IW-1:0]];
      mem_sc[addr] <= bsc_r[cnt_r[IW-1:0]];
      mem_tk[addr] <= btk_r[cnt_r[IW-1:0]];
    end
  end

  // decay scaling of a loaded score
  logic [16:0] keep;
  logic [32:0] dprod;
  logic [15:0] ld_score;

  assign keep     = 17'h10000 - {1'b0, rate_r};
  assign dprod    = {17'b0, rd_sc_r} * {16'b0, keep};
  assign ld_score = (kind_r == KIND_DECAY) ? dprod[31:16] : rd_sc_r;

  // first valid entry holding the id
  logic          hit;
  logic [IW-1:0] hidx;

  always_comb begin
    hit  = 1'b0;
    hidx = '0;
    for (int i = 0; i < NB; i++) begin
      if (!hit && vld_r[i] && bid_r[i] == id_r) begin
        hit  = 1'b1;
        hidx = IW'(i);
      end
    end
  end

  // focus score, clamped
  logic [15:0]        fbase, fscore;
  logic signed [18:0] fsum;

  always_comb begin
    fbase = hit ? bsc_r[hidx] : HALF_SCORE;
    fsum  = $signed({3'b0, fbase}) + $signed({3'b0, boost_r})
          + $signed({{3{extra_r[15]}}, extra_r});
    if (fsum < 0) begin
      fscore = '0;
    end else if (fsum > $signed({3'b0, ceil_r})) begin
      fscore = ceil_r;
    end else begin
      fscore = fsum[15:0];
    end
  end

  // one odd-even transposition pass; invalid entries sink, ties keep order
  logic [NB-1:0] svld;
  logic [31:0]   sid [NB];
  logic [15:0]   ssc [NB];
  logic [31:0]   stk [NB];

  always_comb begin
    svld = vld_r;
    for (int i = 0; i < NB; i++) begin
      sid[i] = bid_r[i];
      ssc[i] = bsc_r[i];
      stk[i] = btk_r[i];
    end
    for (int i = 0; i < NB - 1; i++) begin
      if ((i & 1) == int'(cnt_r[0])) begin
        if ((!vld_r[i] && vld_r[i+1]) ||
            (vld_r[i] && vld_r[i+1] && bsc_r[i] < bsc_r[i+1])) begin
          svld[i]   = vld_r[i+1];
          svld[i+1] = vld_r[i];
          sid[i]    = bid_r[i+1];
          sid[i+1]  = bid_r[i];
          ssc[i]    = bsc_r[i+1];
          ssc[i+1]  = bsc_r[i];
          stk[i]    = btk_r[i+1];
          stk[i+1]  = btk_r[i];
        end
      end
    end
  end

  // kept entries after the limit
  logic [CW-1:0] pop, lim_eff, keep_n;

  always_comb begin
    pop = '0;
    for (int i = 0; i < NB; i++) begin
      pop = pop + CW'(vld_r[i]);
    end
    if (lim_r == 4'd0) begin
      lim_eff = CW'(1);
    end else if (32'(lim_r) > 32'(SLOTS)) begin
      lim_eff = CW'(SLOTS);
    end else begin
      lim_eff = CW'(lim_r);
    end
    keep_n = (pop > lim_eff) ? lim_eff : pop;
  end

  kind_t start_kind;

  always_comb begin
    start_kind = KIND_READ;
    if (in_range) begin
      if (in_data.opcode == OP_FOCUS && en_r) begin
        start_kind = KIND_FOCUS;
      end else if (in_data.opcode == OP_DECAY && en_r) begin
        start_kind = KIND_DECAY;
      end else if (in_data.opcode == OP_TOUCH) begin
        start_kind = KIND_TOUCH;
      end else if (in_data.opcode == OP_CLEAR) begin
        start_kind = KIND_CLEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ctx_r   <= CXW'(in_data.context_index);
      id_r    <= in_data.item_id;
      extra_r <= in_data.extra_boost;
      kind_r  <= start_kind;
    end
    if (cmd.load && cnt_r != '0) begin
      bid_r[cnt_m1[IW-1:0]] <= rd_id_r;
      bsc_r[cnt_m1[IW-1:0]] <= ld_score;
      btk_r[cnt_m1[IW-1:0]] <= rd_tk_r;
    end
    if (cmd.apply) begin
      if (kind_r == KIND_FOCUS) begin
        if (hit) begin
          bsc_r[hidx] <= fscore;
          btk_r[hidx] <= gtick_r;
        end else begin
          bid_r[n_r[IW-1:0]] <= id_r;
          bsc_r[n_r[IW-1:0]] <= fscore;
          btk_r[n_r[IW-1:0]] <= gtick_r;
        end
      end else if (kind_r == KIND_TOUCH && hit) begin
        btk_r[hidx] <= gtick_r;
      end
    end
    if (cmd.sort) begin
      for (int i = 0; i < NB; i++) begin
        bid_r[i] <= sid[i];
        bsc_r[i] <= ssc[i];
        btk_r[i] <= stk[i];
      end
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gtick_r <= '0;
      n_r     <= '0;
      cnt_r   <= '0;
      vld_r   <= '0;
      for (int c = 0; c < CONTEXTS; c++) begin
        fill_r[c] <= '0;
      end
    end else begin
      if (cmd.start) begin
        cnt_r <= '0;
        vld_r <= '0;
        n_r   <= in_range ? fill_r[CXW'(in_data.context_index)] : '0;
        if (in_data.opcode == OP_DECAY && en_r) begin
          gtick_r <= gtick_r + 32'd1;
        end
      end
      if (cmd.load) begin
        if (cnt_r != '0) begin
          vld_r[cnt_m1[IW-1:0]] <= 1'b1;
        end
        if (cnt_r != n_r) begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (cmd.apply) begin
        cnt_r <= '0;
        if (kind_r == KIND_FOCUS && !hit) begin
          vld_r[n_r[IW-1:0]] <= 1'b1;
          n_r                <= n_r + CW'(1);
        end else if (kind_r == KIND_CLEAR) begin
          vld_r         <= '0;
          n_r           <= '0;
          fill_r[ctx_r] <= '0;
        end
      end
      if (cmd.prune) begin
        cnt_r <= '0;
        for (int i = 0; i < NB; i++) begin
          vld_r[i] <= vld_r[i] && (bsc_r[i] >= thr_r);
        end
      end
      if (cmd.sort) begin
        vld_r <= svld;
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.count) begin
        cnt_r         <= '0;
        n_r           <= keep_n;
        fill_r[ctx_r] <= keep_n;
        for (int i = 0; i < NB; i++) begin
          vld_r[i] <= vld_r[i] && (CW'(i) < keep_n);
        end
      end
      if (write_en) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  // result register
  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.respond) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_data_r.found         <= hit;
      out_data_r.score_out     <= hit ? bsc_r[hidx] : 16'd0;
      out_data_r.last_tick_out <= hit ? btk_r[hidx] : 32'd0;
      out_data_r.entry_count   <= 4'(n_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.load_done  = (cnt_r == n_r);
  assign stat.sort_done  = (cnt_r == CW'(NB - 1));
  assign stat.store_done = (cnt_r == n_r);
  assign stat.out_busy   = out_valid_r && !out_ready;
  assign stat.kind       = kind_r;

endmodule

`default_nettype wire

// ===== tb/decaying_focus_table_test.sv =====
`timescale 1ns / 1ps

module decaying_focus_table_test import dft_pkg::*; ();

  class focus_scoreboard;
    logic [31:0] ids [4][9];
    logic [15:0] scs [4][9];
    logic [31:0] tks [4][9];
    int unsigned fill [4];
    logic [31:0] gtick;
    logic        enable;
    logic [15:0] boost, rate, threshold, ceiling;
    logic [3:0]  limit;
    out_t        pending [$];
    int          errors;

    function new();
      gtick = 32'd0; enable = 1'b1; boost = 16'd819; rate = 16'd3277; threshold = 16'd410;
      limit = 4'd8; ceiling = 16'd4096; errors = 0;
      foreach (fill[c]) fill[c] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_FOCUS_ENABLE:    enable = v[0];
        REG_ATTENTION_BOOST: boost = v;
        REG_DECAY_RATE:      rate = v;
        REG_PRUNE_THRESHOLD: threshold = v;
        REG_TABLE_LIMIT:     limit = v[3:0];
        REG_SCORE_CEILING:   ceiling = v;
        default: ;
      endcase
    endfunction

    function int find_id(int c, logic [31:0] id);
      for (int i = 0; i < fill[c]; i++)
        if (ids[c][i] == id) return i;
      return -1;
    endfunction

    function logic [15:0] clamp(longint v);
      if (v < 0) return 16'd0;
      if (v > longint'(ceiling)) return ceiling;
      return v[15:0];
    endfunction

    // prune, stable descending sort, cut to limit
    function void settle(int c, int n);
      int k, j, lim;
      logic [31:0] vi, vt;
      logic [15:0] vs;
      k = 0;
      for (int i = 0; i < n; i++)
        if (scs[c][i] >= threshold) begin
          ids[c][k] = ids[c][i]; scs[c][k] = scs[c][i]; tks[c][k] = tks[c][i];
          k++;
        end
      for (int i = 1; i < k; i++) begin
        vi = ids[c][i]; vs = scs[c][i]; vt = tks[c][i];
        j = i;
        while (j > 0 && scs[c][j-1] < vs) begin
          ids[c][j] = ids[c][j-1]; scs[c][j] = scs[c][j-1]; tks[c][j] = tks[c][j-1];
          j--;
        end
        ids[c][j] = vi; scs[c][j] = vs; tks[c][j] = vt;
      end
      lim = (limit < 1) ? 1 : (limit > 8) ? 8 : limit;
      fill[c] = (k > lim) ? lim : k;
    endfunction

    function void note_request(in_t r);
      int c, n, p;
      out_t o;
      c = r.context_index;
      n = fill[c];
      if (r.opcode == OP_FOCUS && enable) begin
        p = find_id(c, r.item_id);
        if (p >= 0) begin
          scs[c][p] = clamp(longint'(scs[c][p]) + longint'(boost) + longint'(r.extra_boost));
          tks[c][p] = gtick;
        end else begin
          ids[c][n] = r.item_id;
          scs[c][n] = clamp(longint'(HALF_SCORE) + longint'(boost) + longint'(r.extra_boost));
          tks[c][n] = gtick;
          n++;
        end
        settle(c, n);
      end else if (r.opcode == OP_DECAY && enable) begin
        gtick++;
        for (int i = 0; i < n; i++)
          scs[c][i] = 16'((32'(scs[c][i]) * (32'd65536 - 32'(rate))) >> 16);
        settle(c, n);
      end else if (r.opcode == OP_TOUCH) begin
        p = find_id(c, r.item_id);
        if (p >= 0) tks[c][p] = gtick;
      end else if (r.opcode == OP_CLEAR) begin
        fill[c] = 0;
      end
      o = '0;
      p = find_id(c, r.item_id);
      if (p >= 0) begin
        o.found = 1'b1; o.score_out = scs[c][p]; o.last_tick_out = tks[c][p];
      end
      o.entry_count = 4'(fill[c]);
      pending = {pending, o};
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.found !== e.found || got.score_out !== e.score_out ||
          got.last_tick_out !== e.last_tick_out || got.entry_count !== e.entry_count) begin
        $display("%0t: mismatch expected %p actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic in_ready, out_valid, cfg_ready;
  in_t in_data = '0;
  out_t out_data;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  focus_scoreboard board = new();
  longint cycles = 0;
  int hold_off = 0;
  logic [31:0] id_pool [8];

  always #1 clk = ~clk;

  decaying_focus_table dut (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("[decaying_focus_table] ERROR");
      $finish;
    end
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  int gap_len;
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls, including one long hold-off
  initial begin
    @(negedge clk);
    while (1) begin
      if (hold_off > 0) begin
        out_ready <= 0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      if ($urandom_range(0, 40) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(5, 30)) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      @(negedge clk);
    end
  end

  // valid stays up after an accept until the next request or an idle gap
  task automatic send_request(in_t r);
    gap_len = pick_gap();
    if (gap_len > 0) begin
      in_valid <= 0;
      repeat (gap_len) @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(r);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_index <= idx; cfg_data <= v; cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function in_t mk(logic [2:0] op, logic [1:0] c, logic [31:0] id, logic [15:0] x);
    in_t r;
    r.opcode = op; r.context_index = c; r.item_id = id; r.extra_boost = x;
    return r;
  endfunction

  task automatic random_phase(int count, bool_wide);
    in_t r;
    int w;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(0, 99);
      r.context_index = 2'($urandom);
      r.item_id = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, 7)];
      r.extra_boost = bool_wide ? 16'($urandom) : 16'($urandom_range(0, 2048) - 1024);
      if (w < 45) r.opcode = OP_FOCUS;
      else if (w < 60) r.opcode = OP_DECAY;
      else if (w < 75) r.opcode = OP_QUERY;
      else if (w < 88) r.opcode = OP_TOUCH;
      else if (w < 93) r.opcode = OP_CLEAR;
      else r.opcode = 3'($urandom_range(5, 7));
      send_request(r);
    end
  endtask

  initial begin
    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = 32'h0; id_pool[1] = 32'hffff_ffff;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: extremes, every opcode, full table, ties, disabled
    for (int i = 0; i < 9; i++)
      send_request(mk(OP_FOCUS, 2'd0, (i == 8) ? 32'hffff_ffff : 32'(i), 16'h0));
    send_request(mk(OP_FOCUS, 2'd1, 32'h0, 16'h7fff));
    send_request(mk(OP_FOCUS, 2'd1, 32'h1, 16'h8000));
    send_request(mk(OP_DECAY, 2'd0, 32'h3, 16'h0));
    send_request(mk(OP_QUERY, 2'd0, 32'h3, 16'h0));
    send_request(mk(OP_TOUCH, 2'd0, 32'h2, 16'h0));
    send_request(mk(OP_TOUCH, 2'd0, 32'h1234, 16'h0));
    send_request(mk(OP_QUERY, 2'd3, 32'h5555, 16'h0));
    send_request(mk(3'd5, 2'd0, 32'h2, 16'h0));
    send_request(mk(3'd7, 2'd0, 32'h2, 16'h0));
    send_request(mk(OP_CLEAR, 2'd0, 32'h2, 16'h0));
    drain();
    write_reg(REG_FOCUS_ENABLE, 16'd0);
    send_request(mk(OP_FOCUS, 2'd2, 32'h9, 16'h0));
    send_request(mk(OP_DECAY, 2'd1, 32'h0, 16'h0));
    drain();

    // long receiver stall while the sender keeps offering
    write_reg(REG_FOCUS_ENABLE, 16'd1);
    hold_off = 300;
    random_phase(30, 1);
    drain();

    // extreme settings
    write_reg(REG_ATTENTION_BOOST, 16'hffff);
    write_reg(REG_DECAY_RATE, 16'hffff);
    write_reg(REG_PRUNE_THRESHOLD, 16'h0);
    write_reg(REG_TABLE_LIMIT, 16'd1);
    write_reg(REG_SCORE_CEILING, 16'hffff);
    random_phase(120, 1);
    drain();
    write_reg(REG_ATTENTION_BOOST, 16'h0);
    write_reg(REG_DECAY_RATE, 16'h0);
    write_reg(REG_TABLE_LIMIT, 16'd0);
    write_reg(REG_SCORE_CEILING, 16'h0);
    random_phase(60, 1);
    drain();
    write_reg(REG_TABLE_LIMIT, 16'd15);
    write_reg(REG_SCORE_CEILING, 16'd4096);
    write_reg(REG_ATTENTION_BOOST, 16'd400);
    write_reg(REG_DECAY_RATE, 16'd8000);
    write_reg(REG_PRUNE_THRESHOLD, 16'd1000);
    random_phase(300, 0);
    drain();
    write_reg(REG_ATTENTION_BOOST, 16'd819);
    write_reg(REG_DECAY_RATE, 16'd3277);
    write_reg(REG_PRUNE_THRESHOLD, 16'd410);
    write_reg(REG_TABLE_LIMIT, 16'd4);
    random_phase(260, 0);
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("[decaying_focus_table] OK");
    else
      $display("[decaying_focus_table] ERROR");
    $finish;
  end
endmodule
